[hw/rtl/signed_number_to_seven_segment_top_defines.svh]
// Assertion macros for the signed number to seven-segment display block.
`ifndef SIGNED_NUMBER_TO_SEVEN_SEGMENT_TOP_DEFINES_SVH
`define SIGNED_NUMBER_TO_SEVEN_SEGMENT_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SN7SEG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SN7SEG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/sn7seg_pkg.sv]
// Types, constants and the digit pattern table of the seven-segment converter.
package sn7seg_pkg;

   localparam int ValueWidth = 16;
   localparam int MagWidth   = 14;
   localparam int SegWidth   = 7;
   localparam int NumDigits  = 4;

   typedef logic signed [ValueWidth-1:0] value_type;
   typedef logic [MagWidth-1:0]          mag_type;
   typedef logic [SegWidth-1:0]          seg_type;
   typedef logic [3:0]                   digit_type;
   typedef logic [1:0]                   slot_type;

   localparam value_type ValueMin = -16'sd999;
   localparam value_type ValueMax = 16'sd9999;

   localparam seg_type SegBlank = 7'h00;
   localparam seg_type SegMinus = 7'h40;
   localparam seg_type SegE     = 7'h79;

   function automatic seg_type digit_pattern(input digit_type digit);
      seg_type pat;
      case (digit)
         4'd0: pat = 7'h3F;
         4'd1: pat = 7'h06;
         4'd2: pat = 7'h5B;
         4'd3: pat = 7'h4F;
         4'd4: pat = 7'h66;
         4'd5: pat = 7'h6D;
         4'd6: pat = 7'h7D;
         4'd7: pat = 7'h07;
         4'd8: pat = 7'h7F;
         4'd9: pat = 7'h6F;
         default: pat = SegBlank;
      endcase
      return pat;
   endfunction

endpackage

[hw/rtl/signed_number_to_seven_segment_top.sv]
// An accepted req beat reaches its rsp beat through the input register and the result register.
// Throughput: one beat per cycle while rsp_stall is low; the constant-reciprocal digit split fits one stage.
// A held rsp beat stalls req only when the input register is also full.
// Reset (synchronous, active high) empties both registers; no other state exists.
// Converts a signed 16-bit number into four seven-segment patterns and an error flag.
`include "signed_number_to_seven_segment_top_defines.svh"

module signed_number_to_seven_segment_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sn7seg_pkg::value_type      req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sn7seg_pkg::seg_type        rsp_seg_leftmost,
   output sn7seg_pkg::seg_type        rsp_seg_second,
   output sn7seg_pkg::seg_type        rsp_seg_third,
   output sn7seg_pkg::seg_type        rsp_seg_rightmost,
   output logic                       rsp_out_of_range
);

   logic                  in_valid_ff, in_valid_in;
   sn7seg_pkg::value_type in_value_ff;
   logic                  out_valid_ff, out_valid_in;
   sn7seg_pkg::seg_type   out_seg_ff [sn7seg_pkg::NumDigits];
   logic                  out_err_ff;

   logic in_adv, out_adv, req_fire;

   logic                  err, neg;
   logic [15:0]           abs_value;
   sn7seg_pkg::mag_type   mag;
   logic [29:0]           prod10, prod100, prod1000;
   logic [9:0]            q10;
   logic [6:0]            q100;
   sn7seg_pkg::digit_type q1000;
   sn7seg_pkg::digit_type dig [sn7seg_pkg::NumDigits];
   sn7seg_pkg::slot_type  first_slot;
   sn7seg_pkg::seg_type   seg [sn7seg_pkg::NumDigits];

   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign in_adv    = !in_valid_ff || out_adv;
   assign req_stall = !in_adv;
   assign req_fire  = req_valid && in_adv;

   assign in_valid_in  = in_adv ? req_valid : in_valid_ff;
   assign out_valid_in = out_adv ? in_valid_ff : out_valid_ff;

   // split the magnitude into decimal digits
   assign err       = (in_value_ff < sn7seg_pkg::ValueMin) || (in_value_ff > sn7seg_pkg::ValueMax);
   assign neg       = in_value_ff[sn7seg_pkg::ValueWidth-1];
   assign abs_value = neg ? 16'(-in_value_ff) : 16'(in_value_ff);
   assign mag       = err ? '0 : abs_value[sn7seg_pkg::MagWidth-1:0];

   assign prod10   = 30'(mag) * 30'd52429;
   assign prod100  = 30'(mag) * 30'd5243;
   assign prod1000 = 30'(mag) * 30'd16778;
   assign q10      = prod10[28:19];
   assign q100     = prod100[25:19];
   assign q1000    = prod1000[27:24];

   assign dig[3] = 4'(mag - 14'({q10, 3'b000}) - 14'({q10, 1'b0}));
   assign dig[2] = 4'(q10 - 10'({q100, 3'b000}) - 10'({q100, 1'b0}));
   assign dig[1] = 4'(q100 - 7'({q1000, 3'b000}) - 7'({q1000, 1'b0}));
   assign dig[0] = q1000;

   always_comb begin
      if (mag >= 14'd1000) begin
         first_slot = 2'd0;
      end else if (mag >= 14'd100) begin
         first_slot = 2'd1;
      end else if (mag >= 14'd10) begin
         first_slot = 2'd2;
      end else begin
         first_slot = 2'd3;
      end
   end

   always_comb begin
      for (int k = 0; k < sn7seg_pkg::NumDigits; k++) begin
         if (err) begin
            seg[k] = sn7seg_pkg::SegE;
         end else if (2'(k) >= first_slot) begin
            seg[k] = sn7seg_pkg::digit_pattern(dig[k]);
         end else if (neg && (first_slot != 2'd0) && (2'(k) == first_slot - 2'd1)) begin
            seg[k] = sn7seg_pkg::SegMinus;
         end else begin
            seg[k] = sn7seg_pkg::SegBlank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_value_ff <= req_value;
      end
      if (out_adv && in_valid_ff) begin
         out_seg_ff <= seg;
         out_err_ff <= err;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_seg_leftmost  = out_seg_ff[0];
   assign rsp_seg_second    = out_seg_ff[1];
   assign rsp_seg_third     = out_seg_ff[2];
   assign rsp_seg_rightmost = out_seg_ff[3];
   assign rsp_out_of_range  = out_err_ff;

   `SN7SEG_ASSERT_NXT(a_accept_fills, clock, reset, req_valid && !req_stall, in_valid_ff, "accepted beat not captured")
   `SN7SEG_ASSERT_NXT(a_stage_moves, clock, reset, in_valid_ff && !(rsp_valid && rsp_stall), rsp_valid, "input stage beat lost")
   `SN7SEG_ASSERT_IMP(a_err_all_e, clock, reset, rsp_valid && rsp_out_of_range, (rsp_seg_leftmost == sn7seg_pkg::SegE) && (rsp_seg_rightmost == sn7seg_pkg::SegE), "error beat without E")
   `SN7SEG_ASSERT_IMP(a_digit_shown, clock, reset, rsp_valid && !rsp_out_of_range, rsp_seg_rightmost != sn7seg_pkg::SegBlank, "rightmost digit blank")

endmodule
